@@ rtl/lkc_pkg.sv @@
`default_nettype none

package lkc_pkg;

	localparam int ENTRIES = 256;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = IDX_W + 1;
	localparam int RANK_W  = IDX_W;
	localparam int KEY_W   = 32;
	localparam int WORD_W  = 2 * KEY_W + RANK_W;
	localparam int CAP_W   = 9;
	localparam int SLOT_W  = 8;
	localparam int STAT_W  = 2;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

	// register index, taken from paddr word bits
	localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

	localparam logic [STAT_W-1:0] STAT_HIT     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_INSERT  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EVICT   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_INVALID = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0] from_count;
		logic [KEY_W-1:0] to_count;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0]  evicted_from;
		logic [KEY_W-1:0]  evicted_to;
	} rsp_t;

	// sequencer to slot unit
	typedef struct packed {
		logic             clear;
		logic             scan;
		logic             age;
		logic [IDX_W-1:0] idx;
		logic             idx_valid;
		logic [IDX_W-1:0] chosen;
		logic [CNT_W-1:0] bound;
	} slot_ctl_t;

	// scan findings, slot unit to sequencer
	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  hit_slot;
		logic [RANK_W-1:0] hit_rank;
		logic              free_found;
		logic [IDX_W-1:0]  free_slot;
		logic [IDX_W-1:0]  worst_slot;
		logic [RANK_W-1:0] worst_rank;
		logic [KEY_W-1:0]  worst_from;
		logic [KEY_W-1:0]  worst_to;
	} scan_res_t;

endpackage

`default_nettype wire

@@ rtl/lkc_ram.sv @@
`default_nettype none

module lkc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/lkc_slot_unit.sv @@
`default_nettype none

module lkc_slot_unit
	import lkc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire slot_ctl_t         ctl,
	input  wire req_t              key,
	input  wire logic [WORD_W-1:0] rd_data,
	output scan_res_t              res,
	output logic                   wr_en,
	output logic      [WORD_W-1:0] wr_data
);

	logic [KEY_W-1:0]  rd_from;
	logic [KEY_W-1:0]  rd_to;
	logic [RANK_W-1:0] rd_rank;
	logic              match;
	logic              is_chosen;
	scan_res_t         res_q;

	assign rd_from   = rd_data[WORD_W-1 -: KEY_W];
	assign rd_to     = rd_data[RANK_W +: KEY_W];
	assign rd_rank   = rd_data[RANK_W-1:0];
	assign match     = (rd_from == key.from_count) && (rd_to == key.to_count);
	assign is_chosen = (ctl.idx == ctl.chosen);

	// scan: first valid match, lowest free slot, last valid slot of highest rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (ctl.clear) begin
			res_q <= '0;
		end else if (ctl.scan) begin
			if (!res_q.hit && ctl.idx_valid && match) begin
				res_q.hit      <= 1'b1;
				res_q.hit_slot <= ctl.idx;
				res_q.hit_rank <= rd_rank;
			end
			if (!res_q.free_found && !ctl.idx_valid) begin
				res_q.free_found <= 1'b1;
				res_q.free_slot  <= ctl.idx;
			end
			if (ctl.idx_valid && (rd_rank >= res_q.worst_rank)) begin
				res_q.worst_slot <= ctl.idx;
				res_q.worst_rank <= rd_rank;
				res_q.worst_from <= rd_from;
				res_q.worst_to   <= rd_to;
			end
		end
	end

	assign res = res_q;

	// ageing pass: chosen slot takes the key at rank 0, younger valid slots age by one
	always_comb begin
		wr_en   = 1'b0;
		wr_data = rd_data;
		if (ctl.age) begin
			if (is_chosen) begin
				wr_en   = 1'b1;
				wr_data = {key.from_count, key.to_count, {RANK_W{1'b0}}};
			end else if (ctl.idx_valid && ({1'b0, rd_rank} < ctl.bound)) begin
				wr_en   = 1'b1;
				wr_data = {rd_from, rd_to, rd_rank + RANK_W'(1)};
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/lru_key_cache_core.sv @@
`default_nettype none

// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   req_t: from_count, to_count
// rsp       out        rsp_valid / rsp_ready   rsp_t: status, slot, evicted_from, evicted_to
// apb       in/out     psel, penable, pready   capacity_limit at byte address 0
//
// One pass of ENTRIES reads through the key/rank RAM searches, one read-modify-write pass
// ages the ranks; the single RAM port pair sets how long a request occupies the block. A
// key with a zero half skips both passes and goes straight to the response state. Reset
// clears valid bits and occupancy and sets capacity to 256; the RAM itself needs no
// clearing pass. A stalled response holds in the output register while the next request
// is accepted; that request waits at its end for the register.

module lru_key_cache_core
	import lkc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire req_t              req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output rsp_t                   rsp,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_RESP   = 3'd4;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   addr_q;
	logic               rd_pend_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   occ_q;
	logic [CAP_W-1:0]   cap_q;
	req_t               key_q;
	rsp_t               result_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;
	logic [IDX_W-1:0]   chosen_q;
	logic [CNT_W-1:0]   bound_q;

	logic               req_fire;
	logic               cfg_wr;
	logic               issue;
	logic               pass_done;
	logic [CNT_W-1:0]   eff_limit;
	logic               key_bad;
	slot_ctl_t          ctl;
	scan_res_t          res;
	logic [WORD_W-1:0]  rd_data;
	logic               wr_en;
	logic [WORD_W-1:0]  wr_data;

	// APB: never inserts wait states, one register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_CAPACITY);
	assign prdata = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? DATA_W'(cap_q) : '0;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign key_bad   = (req.from_count == '0) || (req.to_count == '0);

	// capacity of zero acts as one, above ENTRIES as ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			eff_limit = CNT_W'(1);
		end else if ({{CNT_W{1'b0}}, cap_q} > (CNT_W + CAP_W)'(ENTRIES)) begin
			eff_limit = CNT_W'(ENTRIES);
		end else begin
			eff_limit = CNT_W'(cap_q);
		end
	end

	// one RAM read per cycle through both passes; read data comes from a registered RAM output
	assign issue     = ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) &&
	                   (addr_q != CNT_W'(ENTRIES));
	assign pass_done = (addr_q == CNT_W'(ENTRIES));

	always_comb begin
		ctl           = '0;
		ctl.clear     = req_fire;
		ctl.scan      = (state_q == ST_SCAN) && rd_pend_s1;
		ctl.age       = (state_q == ST_UPDATE) && rd_pend_s1;
		ctl.idx       = rd_idx_s1;
		ctl.idx_valid = valid_q[rd_idx_s1];
		ctl.chosen    = chosen_q;
		ctl.bound     = bound_q;
	end

	lkc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (rd_idx_s1),
		.wdata (wr_data),
		.raddr (addr_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	lkc_slot_unit u_slot (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.key     (key_q),
		.rd_data (rd_data),
		.res     (res),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
			rd_idx_s1  <= '0;
		end else begin
			rd_pend_s1 <= issue;
			rd_idx_s1  <= addr_q[IDX_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			addr_q      <= '0;
			valid_q     <= '0;
			occ_q       <= '0;
			cap_q       <= CAP_RESET;
			rsp_valid_q <= 1'b0;
			chosen_q    <= '0;
			bound_q     <= '0;
		end else begin
			// load a new answer once the output register is free, else drop the taken one
			if ((state_q == ST_RESP) && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				// a capacity write empties the store
				cap_q   <= pwdata[CAP_W-1:0];
				valid_q <= '0;
				occ_q   <= '0;
			end
			if (issue) begin
				addr_q <= addr_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						addr_q <= '0;
						if (key_bad) begin
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// last read data is folded in this cycle
					if (pass_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					addr_q  <= '0;
					state_q <= ST_UPDATE;
					if (res.hit) begin
						chosen_q <= res.hit_slot;
						bound_q  <= {1'b0, res.hit_rank};
					end else if (occ_q < eff_limit) begin
						chosen_q            <= res.free_slot;
						bound_q             <= CNT_W'(ENTRIES);
						valid_q[res.free_slot] <= 1'b1;
						occ_q               <= occ_q + CNT_W'(1);
					end else begin
						chosen_q <= res.worst_slot;
						bound_q  <= CNT_W'(ENTRIES);
					end
				end
				ST_UPDATE: begin
					if (pass_done) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					// hold until the output register is free
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			key_q <= req;
			if (key_bad) begin
				result_q <= '{status: STAT_INVALID, slot: '0, evicted_from: '0, evicted_to: '0};
			end
		end
		if (state_q == ST_DECIDE) begin
			if (res.hit) begin
				result_q.status       <= STAT_HIT;
				result_q.slot         <= SLOT_W'(res.hit_slot);
				result_q.evicted_from <= '0;
				result_q.evicted_to   <= '0;
			end else if (occ_q < eff_limit) begin
				result_q.status       <= STAT_INSERT;
				result_q.slot         <= SLOT_W'(res.free_slot);
				result_q.evicted_from <= '0;
				result_q.evicted_to   <= '0;
			end else begin
				result_q.status       <= STAT_EVICT;
				result_q.slot         <= SLOT_W'(res.worst_slot);
				result_q.evicted_from <= res.worst_from;
				result_q.evicted_to   <= res.worst_to;
			end
		end
		if ((state_q == ST_RESP) && (!rsp_valid_q || rsp_ready)) begin
			rsp_q <= result_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy differs from number of valid slots");

	a_occ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(ENTRIES))
		else $error("occupancy above store size");

	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) && res.hit |-> valid_q[res.hit_slot])
		else $error("hit on an empty slot");

	a_insert_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) && !res.hit && (occ_q < eff_limit) |-> res.free_found)
		else $error("insert without a free slot");

	a_evict_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) && !res.hit && (occ_q >= eff_limit)
		|-> valid_q[res.worst_slot])
		else $error("eviction of an empty slot");
`endif

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

// Checks the LRU key cache against its own scoreboard. Every request is
// predicted when it is taken. Every answer is compared field by field with the
// oldest prediction. The capacity register is swept through its extremes
// between phases, and each phase is filled and then worked with repeat keys so
// that hits, evictions and invalid keys all occur.
module tb_top;
	import lkc_pkg::*;

	// well over the time one valid request occupies the block, allowed after the last answer
	localparam int unsigned DRAIN_CYCLES = 2 * ENTRIES + 100;
	// the watchdog trips after this many cycles with no transaction anywhere
	localparam int unsigned STALL_LIMIT  = 20000;
	// long receiver hold-off, long enough for a held answer plus a queued request
	localparam int unsigned HOLD_CYCLES  = 2500;
	localparam int          N_PHASES     = 8;

	localparam logic [ADDR_W-3:0] REG_SPARE  = REG_CAPACITY + 1'b1;
	localparam logic [ADDR_W-1:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};
	localparam logic [ADDR_W-1:0] SPARE_ADDR = {REG_SPARE, 2'b00};
	localparam logic [KEY_W-1:0]  KEY_MAX    = '1;

	// capacity settings in order: one, zero (acts as one), small ones, over range, full size
	localparam logic [CAP_W-1:0] CAP_PLAN[N_PHASES] = '{
		9'd1, 9'd0, 9'd2, 9'd3, 9'd7, 9'd16, 9'd511, 9'd256
	};
	localparam int PHASE_ITEMS[N_PHASES] = '{40, 30, 40, 45, 50, 60, 300, 40};

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_t              req_bus   = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	rsp_t              rsp_bus;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// scoreboard copy of the cache
	logic [KEY_W-1:0] held_from[ENTRIES];
	logic [KEY_W-1:0] held_to[ENTRIES];
	bit               held_valid[ENTRIES];
	int unsigned      held_rank[ENTRIES];
	int unsigned      held_count;
	logic [CAP_W-1:0] cap_reg;

	req_t key_requests[$];      // requests waiting for the driver
	rsp_t pending_answers[$];   // predicted answers, oldest first
	req_t key_pool[$];          // keys of the current phase, reused to make hits

	int unsigned keys_offered;
	int unsigned keys_taken;
	int unsigned answers_seen;
	int unsigned fail_cnt;
	int unsigned status_seen[4];
	int unsigned send_gap;
	int unsigned take_gap;
	int unsigned hold_left;
	int unsigned hold_at = 25;
	int unsigned quiet_cycles;
	bit          no_idle;
	rsp_t        want_answer;

	lru_key_cache_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req_bus),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp_bus),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	function automatic void log_failure(input string what);
		fail_cnt++;
		if (fail_cnt <= 10) begin
			$display("MISMATCH at %0t: %s", $time, what);
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			log_failure($sformatf("answer %0d %s: expected 0x%0h, got 0x%0h",
				answers_seen, name, want, got));
		end
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned idle_span();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 85) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 20);
		return $urandom_range(40, 300);
	endfunction

	function automatic void clear_store();
		for (int i = 0; i < ENTRIES; i++) begin
			held_valid[i] = 1'b0;
			held_rank[i]  = 0;
		end
		held_count = 0;
	endfunction

	// Age every valid slot ranked below the bound; the chosen slot becomes most recent.
	function automatic void age_ranks(input int chosen, input int unsigned bound);
		for (int i = 0; i < ENTRIES; i++) begin
			if (held_valid[i] && i != chosen && held_rank[i] < bound) begin
				held_rank[i]++;
			end
		end
		held_rank[chosen] = 0;
	endfunction

	// Work out the answer to one request and update the scoreboard copy.
	function automatic rsp_t lookup_key(input req_t key);
		rsp_t        ans;
		int          hit_slot;
		int          s;
		int unsigned span;
		int unsigned worst;
		ans = '0;
		if (key.from_count == '0 || key.to_count == '0) begin
			ans.status = STAT_INVALID;
			return ans;
		end
		hit_slot = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (held_valid[i] && held_from[i] == key.from_count && held_to[i] == key.to_count) begin
				hit_slot = i;
				break;
			end
		end
		span = (cap_reg == 0) ? 1 : (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
		if (hit_slot >= 0) begin
			ans.status = STAT_HIT;
			ans.slot   = SLOT_W'(hit_slot);
			age_ranks(hit_slot, held_rank[hit_slot]);
		end else if (held_count < span) begin
			// the lowest free slot takes the new key
			s = 0;
			for (int i = 0; i < ENTRIES; i++) begin
				if (!held_valid[i]) begin
					s = i;
					break;
				end
			end
			held_valid[s] = 1'b1;
			held_from[s]  = key.from_count;
			held_to[s]    = key.to_count;
			held_rank[s]  = 0;
			age_ranks(s, 32'hFFFF_FFFF);
			held_count++;
			ans.status = STAT_INSERT;
			ans.slot   = SLOT_W'(s);
		end else begin
			// the highest rank goes; on a tie the last such slot wins
			worst = 0;
			s     = 0;
			for (int i = 0; i < ENTRIES; i++) begin
				if (held_valid[i] && held_rank[i] >= worst) begin
					worst = held_rank[i];
					s     = i;
				end
			end
			ans.status       = STAT_EVICT;
			ans.slot         = SLOT_W'(s);
			ans.evicted_from = held_from[s];
			ans.evicted_to   = held_to[s];
			held_from[s]     = key.from_count;
			held_to[s]       = key.to_count;
			age_ranks(s, 32'hFFFF_FFFF);
		end
		return ans;
	endfunction

	function automatic void push_key(input logic [KEY_W-1:0] from_c, input logic [KEY_W-1:0] to_c);
		key_requests.push_back(req_t'({from_c, to_c}));
	endfunction

	// Mostly keys from the phase pool, with some invalid and some fresh keys mixed in.
	function automatic void queue_random(input int n);
		int unsigned pick;
		req_t        key;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			key  = {$urandom, $urandom};
			if (pick < 4) begin
				key.from_count = '0;
			end else if (pick < 8) begin
				key.to_count = '0;
			end else if (pick < 9) begin
				key = '0;
			end else if (pick >= 15) begin
				key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			end
			key_requests.push_back(key);
		end
	endfunction

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		// only the capacity register exists; a write there empties the store
		if (addr[ADDR_W-1:2] == REG_CAPACITY) begin
			cap_reg = data[CAP_W-1:0];
			clear_store();
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_read_check(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] want);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want) begin
			log_failure($sformatf("register read at 0x%0h: expected 0x%0h, got 0x%0h",
				addr, want, prdata));
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Return once every queued request has been taken and answered.
	task automatic wait_drained();
		@(negedge clk);
		while (key_requests.size() != 0 || keys_taken != keys_offered ||
				pending_answers.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// Request driver: hold each transaction until it is taken, then idle for a
	// random gap, none in phases without gaps, before presenting the next one.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (req_valid && keys_taken != keys_offered) begin
			// hold payload and valid until the handshake completes
		end else if (send_gap > 0) begin
			req_valid <= 1'b0;
			send_gap--;
		end else if (key_requests.size() > 0) begin
			req_bus   <= key_requests.pop_front();
			req_valid <= 1'b1;
			keys_offered++;
			send_gap = no_idle ? 0 : idle_span();
		end else begin
			req_valid <= 1'b0;
		end
	end

	// Answer receiver: random stalls, plus two long hold-offs so that the block
	// fills up behind a held answer and stops taking requests.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left--;
		end else if (answers_seen >= hold_at) begin
			rsp_ready <= 1'b0;
			hold_left = HOLD_CYCLES;
			hold_at   = (hold_at < 400) ? 450 : 32'hFFFF_FFFF;
		end else if (take_gap > 0) begin
			rsp_ready <= 1'b0;
			take_gap--;
		end else begin
			rsp_ready <= 1'b1;
			take_gap = no_idle ? 0 : idle_span();
		end
	end

	// Monitor: check the answer first, so a same-edge request can never cover
	// for an answer that nothing asked for; then predict the taken request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				answers_seen++;
				if (pending_answers.size() == 0) begin
					log_failure($sformatf("answer %0d with nothing outstanding: status %0d slot %0d",
						answers_seen, rsp_bus.status, rsp_bus.slot));
				end else begin
					want_answer = pending_answers.pop_front();
					status_seen[want_answer.status]++;
					check_field("status", 32'(want_answer.status), 32'(rsp_bus.status));
					check_field("slot", 32'(want_answer.slot), 32'(rsp_bus.slot));
					check_field("evicted_from", want_answer.evicted_from, rsp_bus.evicted_from);
					check_field("evicted_to", want_answer.evicted_to, rsp_bus.evicted_to);
				end
			end
			if (req_valid && req_ready) begin
				pending_answers.push_back(lookup_key(req_bus));
				keys_taken++;
			end
		end
	end

	// Watchdog: any transaction on any port restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : main_seq
		logic [DATA_W-1:0] wdata;
		int unsigned       span;
		int                pool_n;
		int unsigned       pick;
		req_t              key;

		cap_reg = CAP_RESET;
		clear_store();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		apb_read_check(CAP_ADDR, DATA_W'(CAP_RESET));

		// Directed start at reset capacity: invalid halves, extreme counts,
		// keys sharing one half, hits on recent and older entries.
		push_key('0, '0);
		push_key('0, KEY_MAX);
		push_key(KEY_MAX, '0);
		push_key(32'h1, 32'h1);
		push_key(KEY_MAX, KEY_MAX);
		push_key(32'h1, KEY_MAX);
		push_key(KEY_MAX, 32'h1);
		push_key(32'h8000_0000, 32'h1);
		push_key(32'hAAAA_AAAA, 32'h5555_5555);
		push_key(32'h5555_5555, 32'hAAAA_AAAA);
		push_key(32'h1, 32'h1);
		push_key(KEY_MAX, 32'h1);
		push_key(32'h5555_5555, 32'hAAAA_AAAA);
		push_key('0, 32'h1);
		push_key(32'h1, 32'h1);
		push_key(KEY_MAX, KEY_MAX);
		push_key(32'h7FFF_FFFF, 32'h8000_0000);
		wait_drained();

		for (int p = 0; p < N_PHASES; p++) begin
			// every third phase runs without gaps on either side
			no_idle = (p % 3 == 2);
			wdata = $urandom;
			wdata[CAP_W-1:0] = CAP_PLAN[p];
			apb_write(CAP_ADDR, wdata);
			apb_read_check(CAP_ADDR, DATA_W'(CAP_PLAN[p]));

			// Build a pool a little larger than the capacity, or of half the phase's items when
			// that would not fit, offer it once in order to fill the store, then draw from it at random.
			span = (CAP_PLAN[p] == 0) ? 1 : (CAP_PLAN[p] > ENTRIES) ? ENTRIES : CAP_PLAN[p];
			pool_n = span + 3;
			if (pool_n > PHASE_ITEMS[p]) pool_n = PHASE_ITEMS[p] / 2;
			key_pool.delete();
			for (int i = 0; i < pool_n; i++) begin
				pick = $urandom_range(0, 99);
				key  = {$urandom, $urandom};
				if (i > 0 && pick < 15) begin
					key.from_count = key_pool[i-1].from_count;
				end else if (i > 0 && pick < 30) begin
					key.to_count = key_pool[i-1].to_count;
				end else if (pick < 36) begin
					key.from_count = $urandom_range(0, 1) ? KEY_MAX : 32'h1;
				end
				key_pool.push_back(key);
				key_requests.push_back(key);
			end
			queue_random(PHASE_ITEMS[p] - pool_n);
			wait_drained();

			// a write to an unused address must leave the store as it is
			if (CAP_PLAN[p] == 9'd16) begin
				apb_write(SPARE_ADDR, $urandom);
				queue_random(20);
				wait_drained();
			end
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_answers.size() != 0) begin
			log_failure($sformatf("%0d answers never arrived", pending_answers.size()));
		end

		$display("Ran %0d key requests over the reset capacity and %0d written settings.",
			keys_taken, N_PHASES);
		$display("Answers: %0d hits, %0d inserts, %0d evictions, %0d invalid keys; %0d failures.",
			status_seen[STAT_HIT], status_seen[STAT_INSERT], status_seen[STAT_EVICT],
			status_seen[STAT_INVALID], fail_cnt);
		if (fail_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/lkc_pkg.sv
rtl/lkc_ram.sv
rtl/lkc_slot_unit.sv
rtl/lru_key_cache_core.sv
dv/tb_top.sv
